// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths and types for the modexp / base-2 generator test unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_BITS = 16;

    typedef logic [MOD_BITS-1:0]   t_word;
    typedef logic [2*MOD_BITS-1:0] t_dword;

    // Function codes
    localparam logic FUNC_MODEXP = 1'b0;
    localparam logic FUNC_GENTEST = 1'b1;

    typedef struct packed {
        logic func;
        t_word base;
        t_word exponent;
        t_word modulus;
    } t_req;

    typedef struct packed {
        t_word value;
        logic  is_generator;
        logic  error;
    } t_rsp;

    // Divider command and status between sequencer and shared divider
    typedef struct packed {
        logic   start;
        t_dword dividend;
        t_word  divisor;
    } t_div_cmd;

    typedef struct packed {
        logic   done;
        t_dword quotient;
        t_word  remainder;
    } t_div_sts;

endpackage

// ===== hdl/mexp_stream_if.sv =====
// ----------------------------------------------------------------------------
// mexp_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface mexp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mexp_div.sv =====
// ----------------------------------------------------------------------------
// mexp_div
// Shared restoring divider: 2*MOD_BITS-bit dividend by MOD_BITS-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mexp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mexp_pkg::t_div_cmd i_cmd,
    output mexp_pkg::t_div_sts o_sts
);
    import mexp_pkg::*;

    localparam int QB = 2 * MOD_BITS;
    localparam int CB = $clog2(QB + 1);

    logic           r_busy;
    logic [CB-1:0]  r_cnt;
    t_dword         r_quo;
    logic [MOD_BITS:0] r_rem;
    t_word          r_dvs;
    logic           r_done;

    logic [MOD_BITS+1:0] w_trial;
    logic [MOD_BITS:0]   w_shift;

    // Shift in the next dividend bit and try a subtract
    assign w_shift = {r_rem[MOD_BITS-1:0], r_quo[QB-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(QB);
                r_quo  <= i_cmd.dividend;
                r_rem  <= '0;
                r_dvs  <= i_cmd.divisor;
            end else if (r_busy) begin
                if (!w_trial[MOD_BITS+1]) begin
                    r_rem <= w_trial[MOD_BITS:0];
                    r_quo <= {r_quo[QB-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[QB-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done      = r_done;
    assign o_sts.quotient  = r_quo;
    assign o_sts.remainder = r_rem[MOD_BITS-1:0];

endmodule

// ===== hdl/modexp_and_base2_primitive_root_test_unit.sv =====
// ----------------------------------------------------------------------------
// modexp_and_base2_primitive_root_test_unit
// Modular exponentiation, or test whether 2 generates the group mod p.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  i_req     in   func, base, exponent, modulus
//  o_rsp     out  value, is_generator, error
//
//  Every product and remainder goes through one shared divider. Exponentiation
//  costs about 2*bits(exponent)+1 divider runs; the generator test runs one
//  remainder per odd trial divisor up to sqrt(p-1), plus a power for each
//  prime factor.
//  One item at a time; i_req is ready only when idle. Reset is synchronous.
//  The result is held in o_rsp until taken.
module modexp_and_base2_primitive_root_test_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mexp_stream_if.sink   i_req,
    mexp_stream_if.source o_rsp
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PW_INIT, S_PW_LOOP, S_PW_MUL, S_PW_SQ, S_PW_END,
        S_GT_START, S_GT_Q2, S_GT_HALVE, S_GT_TRY, S_GT_DIVCHK,
        S_GT_QUO, S_GT_STRIP, S_GT_NEXT, S_GT_LAST, S_GT_LASTQ,
        S_WAIT, S_OUT
    } t_state;

    t_state r_state, r_ret, r_pret;
    t_req   r_req;
    t_word  r_acc, r_b, r_m, r_n, r_d, r_pm1;
    t_word  r_e;
    logic   r_mul;
    t_rsp   r_rsp;
    t_div_cmd r_cmd;
    t_div_sts w_sts;
    t_dword w_dsq;

    mexp_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(r_cmd), .o_sts(w_sts));

    assign w_dsq = {{MOD_BITS{1'b0}}, r_d} * {{MOD_BITS{1'b0}}, r_d};

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = r_rsp;

    // Sequencer: each divide is issued and then waited on in S_WAIT until done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd.start <= 1'b0;
        end else begin
            r_cmd.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        if (i_req.data.func == FUNC_MODEXP) begin
                            if (i_req.data.modulus == '0) begin
                                r_rsp <= '{value: '0, is_generator: 1'b0, error: 1'b1};
                                r_state <= S_OUT;
                            end else begin
                                r_rsp <= '0;
                                r_b <= i_req.data.base;
                                r_e <= i_req.data.exponent;
                                r_m <= i_req.data.modulus;
                                r_pret <= S_PW_END;
                                r_state <= S_PW_INIT;
                            end
                        end else begin
                            r_rsp <= '0;
                            r_state <= S_GT_START;
                        end
                    end
                end
                // Power: reduce the base first
                S_PW_INIT: begin
                    r_acc <= MOD_BITS'(1);
                    r_cmd.start <= 1'b1;
                    r_cmd.dividend <= {{MOD_BITS{1'b0}}, r_b};
                    r_cmd.divisor <= r_m;
                    r_ret <= S_PW_LOOP;
                    r_state <= S_WAIT;
                end
                S_PW_LOOP: begin
                    if (r_ret == S_PW_LOOP) r_b <= w_sts.remainder;
                    r_ret <= S_PW_MUL;
                    if (r_e == '0) begin
                        r_state <= r_pret;
                    end else if (r_e[0]) begin
                        r_cmd.start <= 1'b1;
                        r_cmd.dividend <= {{MOD_BITS{1'b0}}, r_acc} *
                                          {{MOD_BITS{1'b0}}, ((r_ret == S_PW_LOOP) ?
                                           w_sts.remainder : r_b)};
                        r_cmd.divisor <= r_m;
                        r_mul <= 1'b1;
                        r_state <= S_WAIT;
                    end else begin
                        r_mul <= 1'b0;
                        r_state <= S_PW_MUL;
                    end
                end
                S_PW_MUL: begin
                    if (r_mul) r_acc <= w_sts.remainder;
                    r_e <= r_e >> 1;
                    r_cmd.start <= 1'b1;
                    r_cmd.dividend <= {{MOD_BITS{1'b0}}, r_b} * {{MOD_BITS{1'b0}}, r_b};
                    r_cmd.divisor <= r_m;
                    r_ret <= S_PW_SQ;
                    r_state <= S_WAIT;
                end
                S_PW_SQ: begin
                    r_b <= w_sts.remainder;
                    r_ret <= S_PW_SQ;
                    r_state <= S_PW_LOOP;
                end
                S_PW_END: begin
                    r_rsp.value <= r_acc;
                    r_state <= S_OUT;
                end
                // Generator test
                S_GT_START: begin
                    if (r_req.modulus == MOD_BITS'(2)) begin
                        r_rsp.is_generator <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_req.modulus[2:0] != 3'd3 &&
                                 r_req.modulus[2:0] != 3'd5) begin
                        r_state <= S_OUT;
                    end else begin
                        // p odd here, so p-1 is even and nonzero
                        r_pm1 <= r_req.modulus - 1'b1;
                        r_n <= r_req.modulus - 1'b1;
                        r_b <= MOD_BITS'(2);
                        r_e <= (r_req.modulus - 1'b1) >> 1;
                        r_m <= r_req.modulus;
                        r_pret <= S_GT_Q2;
                        r_state <= S_PW_INIT;
                    end
                end
                S_GT_Q2: begin
                    if (r_acc == MOD_BITS'(1)) r_state <= S_OUT;
                    else r_state <= S_GT_HALVE;
                end
                S_GT_HALVE: begin
                    if (r_n[0]) begin
                        r_d <= MOD_BITS'(3);
                        r_state <= S_GT_TRY;
                    end else begin
                        r_n <= r_n >> 1;
                    end
                end
                S_GT_TRY: begin
                    if (w_dsq > {{MOD_BITS{1'b0}}, r_pm1}) begin
                        r_state <= S_GT_LAST;
                    end else begin
                        r_cmd.start <= 1'b1;
                        r_cmd.dividend <= {{MOD_BITS{1'b0}}, r_n};
                        r_cmd.divisor <= r_d;
                        r_ret <= S_GT_DIVCHK;
                        r_state <= S_WAIT;
                    end
                end
                S_GT_DIVCHK: begin
                    if (w_sts.remainder != '0) begin
                        r_state <= S_GT_NEXT;
                    end else begin
                        r_cmd.start <= 1'b1;
                        r_cmd.dividend <= {{MOD_BITS{1'b0}}, r_pm1};
                        r_cmd.divisor <= r_d;
                        r_ret <= S_GT_QUO;
                        r_state <= S_WAIT;
                    end
                end
                S_GT_QUO: begin
                    r_b <= MOD_BITS'(2);
                    r_e <= w_sts.quotient[MOD_BITS-1:0];
                    r_pret <= S_GT_STRIP;
                    r_state <= S_PW_INIT;
                end
                // Strip every copy of d from n; pass 0 through first divide
                S_GT_STRIP: begin
                    if (r_acc == MOD_BITS'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cmd.start <= 1'b1;
                        r_cmd.dividend <= {{MOD_BITS{1'b0}}, r_n};
                        r_cmd.divisor <= r_d;
                        r_acc <= '0;
                        r_ret <= S_GT_NEXT;
                        r_state <= S_WAIT;
                        r_mul <= 1'b1;
                    end
                end
                S_GT_NEXT: begin
                    if (r_mul && w_sts.remainder == '0 && r_n != '0) begin
                        r_n <= w_sts.quotient[MOD_BITS-1:0];
                        r_cmd.start <= 1'b1;
                        r_cmd.dividend <= {{MOD_BITS{1'b0}}, w_sts.quotient[MOD_BITS-1:0]};
                        r_cmd.divisor <= r_d;
                        r_ret <= S_GT_NEXT;
                        r_state <= S_WAIT;
                    end else begin
                        r_mul <= 1'b0;
                        r_d <= r_d + MOD_BITS'(2);
                        r_state <= S_GT_TRY;
                    end
                end
                S_GT_LAST: begin
                    if (r_pret == S_GT_LAST) begin
                        // Last factor power has returned: decide on acc
                        r_rsp.is_generator <= (r_acc != MOD_BITS'(1));
                        r_state <= S_OUT;
                    end else if (r_n > MOD_BITS'(1)) begin
                        r_cmd.start <= 1'b1;
                        r_cmd.dividend <= {{MOD_BITS{1'b0}}, r_pm1};
                        r_cmd.divisor <= r_n;
                        r_ret <= S_GT_LASTQ;
                        r_state <= S_WAIT;
                    end else begin
                        r_rsp.is_generator <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_GT_LASTQ: begin
                    r_b <= MOD_BITS'(2);
                    r_e <= w_sts.quotient[MOD_BITS-1:0];
                    r_n <= '0;
                    r_pret <= S_GT_LAST;
                    r_state <= S_PW_INIT;
                end
                S_WAIT: begin
                    if (w_sts.done) r_state <= r_ret;
                end
                S_OUT: begin
                    if (o_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.data.error && o_rsp.data.is_generator))
        else $error("error and is_generator both set");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> $stable(o_rsp.data))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.start |=> r_state == S_WAIT)
        else $error("divide issued outside wait");

endmodule

// ===== tb/tb_modexp_and_base2_primitive_root_test_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modexp_and_base2_primitive_root_test_unit
// Drives exponentiation and base-2 generator requests with random idle gaps
// on both channels, predicts each response in the bench and compares it field
// by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_modexp_and_base2_primitive_root_test_unit;
    import mexp_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   n_fail;
    int   resp_hold;
    t_rsp pending_rsp[$];

    mexp_stream_if #(.T(t_req)) req_if ();
    mexp_stream_if #(.T(t_rsp)) rsp_if ();

    modexp_and_base2_primitive_root_test_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Square-and-multiply power, full-width products
    function automatic longint unsigned power_mod(longint unsigned b, longint unsigned e,
                                                  longint unsigned m);
        longint unsigned acc;
        acc = 1;
        if (m == 0) return 0;
        b = b % m;
        while (e > 0) begin
            if (e[0]) acc = (acc * b) % m;
            e = e >> 1;
            b = (b * b) % m;
        end
        return acc;
    endfunction

    // Decide whether 2 generates the group modulo p
    function automatic bit two_is_generator(longint unsigned p);
        longint unsigned pm1, n, d;
        if (p == 2) return 1'b1;
        if (p % 8 != 3 && p % 8 != 5) return 1'b0;
        pm1 = p - 1;
        n = pm1;
        if (n % 2 == 0) begin
            if (power_mod(64'd2, pm1 / 2, p) == 1) return 1'b0;
            while (n != 0 && n % 2 == 0) n = n / 2;
        end
        for (d = 3; d * d <= pm1; d += 2) begin
            if (n % d == 0) begin
                if (power_mod(64'd2, pm1 / d, p) == 1) return 1'b0;
                while (n != 0 && n % d == 0) n = n / d;
            end
        end
        if (n > 1 && power_mod(64'd2, pm1 / n, p) == 1) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_rsp predict_rsp(t_req rq);
        t_rsp r;
        r = '0;
        if (rq.func == FUNC_MODEXP) begin
            if (rq.modulus == 0) r.error = 1'b1;
            else r.value = t_word'(power_mod(64'(rq.base), 64'(rq.exponent),
                                             64'(rq.modulus)));
        end else begin
            r.is_generator = two_is_generator(64'(rq.modulus));
        end
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 19);
        if (k < 10) return 0;
        if (k < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request beat, record its prediction on acceptance
    task automatic send_req(logic f, t_word b, t_word e, t_word m);
        t_req rq;
        int   g;
        rq.func = f;
        rq.base = b;
        rq.exponent = e;
        rq.modulus = m;
        g = gap_len();
        if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= rq;
        do @(posedge i_clk); while (!req_if.ready);
        pending_rsp.push_back(predict_rsp(rq));
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        int g;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (resp_hold > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (resp_hold) @(posedge i_clk);
                resp_hold = 0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare each response beat with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected response beat");
                n_fail++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.data.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, rsp_if.data.value);
                    n_fail++;
                end
                if (rsp_if.data.is_generator !== want.is_generator) begin
                    $error("is_generator: expected %0d, got %0d",
                           want.is_generator, rsp_if.data.is_generator);
                    n_fail++;
                end
                if (rsp_if.data.error !== want.error) begin
                    $error("error: expected %0d, got %0d", want.error, rsp_if.data.error);
                    n_fail++;
                end
            end
        end
    end

    task automatic test_modexp_corners();
        send_req(FUNC_MODEXP, 16'd7, 16'd5, 16'd0);
        send_req(FUNC_MODEXP, 16'hFFFF, 16'hFFFF, 16'd0);
        send_req(FUNC_MODEXP, 16'd9, 16'd0, 16'd1);
        send_req(FUNC_MODEXP, 16'd9, 16'd0, 16'd13);
        send_req(FUNC_MODEXP, 16'd9, 16'd3, 16'd1);
        send_req(FUNC_MODEXP, 16'd0, 16'd0, 16'hFFFF);
        send_req(FUNC_MODEXP, 16'd0, 16'd4, 16'd11);
        send_req(FUNC_MODEXP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(FUNC_MODEXP, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        send_req(FUNC_MODEXP, 16'hAAAA, 16'h5555, 16'hFFF1);
        send_req(FUNC_MODEXP, 16'h5555, 16'hAAAA, 16'h8000);
    endtask

    task automatic test_generator_corners();
        t_word c[12] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5, 16'd7, 16'd11,
                         16'd17, 16'd35, 16'd65531, 16'd65533, 16'hFFFF};
        foreach (c[i]) send_req(FUNC_GENTEST, t_word'($urandom), t_word'($urandom), c[i]);
    endtask

    task automatic test_random_mix(int n);
        t_word m;
        repeat (n) begin
            if ($urandom_range(0, 1)) begin
                // bias towards candidates that are 3 or 5 mod 8
                m = t_word'($urandom);
                if ($urandom_range(0, 3) != 0) m[2:0] = $urandom_range(0, 1) ? 3'd3 : 3'd5;
                if ($urandom_range(0, 3) == 0) m = m & 16'h00FF;
                send_req(FUNC_GENTEST, t_word'($urandom), t_word'($urandom), m);
            end else begin
                m = t_word'($urandom);
                if ($urandom_range(0, 9) == 0) m = t_word'($urandom_range(0, 2));
                send_req(FUNC_MODEXP, t_word'($urandom), t_word'($urandom), m);
            end
        end
    endtask

    // Hold the receiver off long enough that the block stalls its input
    task automatic test_backpressure();
        resp_hold = 3000;
        repeat (4) send_req(FUNC_MODEXP, t_word'($urandom), t_word'($urandom),
                            t_word'($urandom));
    endtask

    initial begin
        n_fail = 0;
        resp_hold = 0;
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_modexp_corners();
        test_generator_corners();
        test_backpressure();
        test_random_mix(115);
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_fail == 0 && pending_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Timeout
    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
